// File: sv/mdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdec_pkg: morse decoder shared types and constants
// Symbol class codes, byte values and the letter/digit code table.
// ----------------------------------------------------------------------------
package mdec_pkg;

    typedef logic [1:0] sym_class_t;

    localparam sym_class_t CLS_DOT   = 2'd0;
    localparam sym_class_t CLS_DASH  = 2'd1;
    localparam sym_class_t CLS_SPACE = 2'd2;
    localparam sym_class_t CLS_OTHER = 2'd3;

    localparam logic [7:0] BYTE_DOT   = 8'd46;
    localparam logic [7:0] BYTE_DASH  = 8'd45;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_A     = 7'd65;
    localparam logic [6:0] CHAR_0     = 7'd48;

    localparam int unsigned MAX_LEN     = 5;
    localparam int unsigned TABLE_N     = 36;
    localparam int unsigned LETTER_N    = 26;

    typedef logic [4:0] pat_bits_t;
    typedef logic [2:0] pat_len_t;

    // bit i set when symbol i is a dash; order A..Z then 0..9
    localparam pat_bits_t CODE_BITS [TABLE_N] = '{
        5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,
        5'd14, 5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,
        5'd0,  5'd1,  5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
        5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,
        5'd3,  5'd7,  5'd15
    };

    localparam pat_len_t CODE_LEN [TABLE_N] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
        3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd5
    };

    // head of the queue as seen by the back end
    typedef struct packed {
        logic       valid;
        sym_class_t cls;
    } queue_head_t;

    function automatic sym_class_t classify(input logic [7:0] b);
        sym_class_t c;
        c = CLS_OTHER;
        if (b == BYTE_DOT)
            c = CLS_DOT;
        else if (b == BYTE_DASH)
            c = CLS_DASH;
        else if (b == BYTE_SPACE)
            c = CLS_SPACE;
        return c;
    endfunction

    // parallel match over all entries; zero when nothing matches
    function automatic logic [6:0] lookup(input pat_bits_t bits, input pat_len_t len);
        logic [6:0] ch;
        ch = 7'd0;
        for (int k = TABLE_N - 1; k >= 0; k--)
        begin
            if (bits == CODE_BITS[k] && len == CODE_LEN[k])
            begin
                if (k < LETTER_N)
                    ch = CHAR_A + 7'(k);
                else
                    ch = CHAR_0 + 7'(k - LETTER_N);
            end
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: sv/mdec_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdec_sym_if / mdec_chr_if: valid/ready channels
// Symbol byte channel into the decoder and character channel out of it.
// ----------------------------------------------------------------------------
interface mdec_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface mdec_chr_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface
`default_nettype wire

// File: sv/mdec_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdec_front: symbol intake
// Accepts symbol beats and classifies each byte for the queue.
// ----------------------------------------------------------------------------
module mdec_front
    import mdec_pkg::*;
(
    mdec_sym_if.sink   sym,
    input  wire logic  queue_full,
    output sym_class_t push_cls,
    output logic       push
);

    assign sym.ready = !queue_full;
    assign push      = sym.valid && !queue_full;
    assign push_cls  = classify(sym.symbol);

endmodule
`default_nettype wire

// File: sv/mdec_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdec_queue: symbol class queue
// Small FIFO that decouples intake from pattern handling.
// ----------------------------------------------------------------------------
module mdec_queue
    import mdec_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire sym_class_t  push_cls,
    input  wire logic        pop,
    output logic             full,
    output queue_head_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sym_class_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_FULL);
    assign head = '{valid: (count_reg != '0), cls: mem_reg[rd_ptr_reg]};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cls;
    end

endmodule
`default_nettype wire

// File: sv/mdec_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdec_back: pattern builder and lookup
// Holds the pattern and space run, looks patterns up, drives the output.
// ----------------------------------------------------------------------------
module mdec_back
    import mdec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire queue_head_t head,
    output logic             pop,
    mdec_chr_if.source       chr
);

    pat_bits_t  bits_reg, bits_next;
    pat_len_t   len_reg, len_next;
    logic       invalid_reg, invalid_next;
    logic [1:0] run_reg, run_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_char_reg, out_char_next;

    logic       emit;
    logic [6:0] emit_char;
    logic [6:0] found;

    assign found = (invalid_reg || len_reg == '0) ? 7'd0 : lookup(bits_reg, len_reg);

    always_comb
    begin
        bits_next    = bits_reg;
        len_next     = len_reg;
        invalid_next = invalid_reg;
        run_next     = run_reg;
        emit         = 1'b0;
        emit_char    = found;
        case (head.cls)
            CLS_SPACE:
            begin
                run_next = (run_reg == 2'd3) ? 2'd3 : run_reg + 2'd1;
                if (run_next == 2'd2)
                begin
                    emit      = 1'b1;
                    emit_char = CHAR_SPACE;
                end
                else
                begin
                    emit         = (found != 7'd0);
                    bits_next    = '0;
                    len_next     = '0;
                    invalid_next = 1'b0;
                end
            end
            CLS_DOT, CLS_DASH:
            begin
                run_next = 2'd0;
                if (len_reg < pat_len_t'(MAX_LEN))
                begin
                    if (head.cls == CLS_DASH)
                        bits_next = bits_reg | (5'd1 << len_reg);
                    len_next = len_reg + 3'd1;
                end
                else
                    invalid_next = 1'b1;
            end
            default:
            begin
                run_next     = 2'd0;
                invalid_next = 1'b1;
            end
        endcase
    end

    // a beat that emits nothing never waits on the output
    assign pop = head.valid && (!emit || !out_valid_reg || chr.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        if (out_valid_reg && chr.ready)
            out_valid_next = 1'b0;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            len_reg       <= '0;
            invalid_reg   <= 1'b0;
            run_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                bits_reg    <= bits_next;
                len_reg     <= len_next;
                invalid_reg <= invalid_next;
                run_reg     <= run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
    end

    assign chr.valid     = out_valid_reg;
    assign chr.character = out_char_reg;

endmodule
`default_nettype wire

// File: sv/morse_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_decoder_core: international morse code decoder
// Turns dot/dash/space bytes into ASCII letters, digits and word spaces.
// ----------------------------------------------------------------------------
//  port   dir  payload           beat
//  sym    in   symbol[7:0]       one morse byte
//  chr    out  character[6:0]    one decoded character or word space
//
//  one symbol beat per cycle while the queue is not full; a character follows its
//  space beat through the queue entry, then the output register
//  rst_n clears the pattern, space run, queue and output valid at once
//  the symbol queue holds QUEUE_DEPTH beats; intake stalls when it is full,
//  which for QUEUE_DEPTH > 1 happens only while output waits on chr.ready
// ----------------------------------------------------------------------------
module morse_decoder_core
    import mdec_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mdec_sym_if.sink    sym,
    mdec_chr_if.source  chr
);

    logic        queue_full;
    logic        push;
    sym_class_t  push_cls;
    logic        pop;
    queue_head_t head;

    mdec_front u_front (
        .sym        (sym),
        .queue_full (queue_full),
        .push_cls   (push_cls),
        .push       (push)
    );

    mdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cls (push_cls),
        .pop      (pop),
        .full     (queue_full),
        .head     (head)
    );

    mdec_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .chr   (chr)
    );

endmodule
`default_nettype wire
